FILE: rtl/ptc_pkg.sv
// types, constants and helpers shared by the perceptron train and classify block
package ptc_pkg;

   localparam int FEATURES_DEFAULT = 16;
   localparam int ACC_W = 56;
   localparam int WEIGHT_W = 32;
   localparam int FEAT_W = 16;
   localparam int RATE_W = 16;
   localparam logic [RATE_W-1:0] RATE_RESET = 16'd13107;

   typedef enum logic {
      CMD_CLASSIFY = 1'b0,
      CMD_TRAIN    = 1'b1
   } cmd_code_type;

   typedef struct packed {
      logic                     cmd;
      logic signed [FEAT_W-1:0] feature_value;
      logic                     label;
      logic                     last;
   } req_payload_type;

   typedef struct packed {
      logic predicted_class;
      logic mistake;
   } rsp_payload_type;

   typedef struct packed {
      logic accept;
      logic mac;
      logic sum;
      logic bias;
      logic upd_start;
      logic upd_rd;
      logic upd_mul;
      logic upd_wr;
      logic out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic last_item;
      logic mistake;
      logic count_nonzero;
      logic upd_more;
      logic rsp_busy;
   } dp_status_type;

   function automatic logic signed [WEIGHT_W-1:0] sat32(input logic signed [WEIGHT_W+1:0] v);
      logic signed [WEIGHT_W+1:0] hi;
      logic signed [WEIGHT_W+1:0] lo;
      hi = 34'sd2147483647;
      lo = -34'sd2147483648;
      if (v > hi) begin
         return 32'sh7FFFFFFF;
      end else if (v < lo) begin
         return 32'sh80000000;
      end else begin
         return v[WEIGHT_W-1:0];
      end
   endfunction

endpackage

FILE: rtl/perceptron_train_classify.sv
// item without last: accept, then one multiply-accumulate, then back to idle for the next accept
// item with last: accept, multiply-accumulate, sum, check, result load; a training mistake also
// moves the bias and adds, for each of N buffered features, one weight read, multiply and write
// through the weight memory port; the next item is taken once the result is in the output register
// reset: synchronous, clears weights, bias, accumulator, feature count, result valid; rate 13107
module perceptron_train_classify #(
   parameter int FEATURES = ptc_pkg::FEATURES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  ptc_pkg::req_payload_type    req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output ptc_pkg::rsp_payload_type    rsp_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ptc_pkg::RATE_W-1:0]  csr_data
);
   import ptc_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type sts;

   assign csr_ready = 1'b1;

   ptc_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts_i     (sts),
      .cmd_o     (cmd)
   );

   ptc_datapath #(
      .FEATURES (FEATURES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd_i       (cmd),
      .sts_o       (sts),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data)
   );

endmodule

FILE: rtl/ptc_datapath.sv
// datapath: feature and weight memories, accumulator, bias, update arithmetic, result register
module ptc_datapath #(
   parameter int FEATURES = ptc_pkg::FEATURES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ptc_pkg::ctl_cmd_type          cmd_i,
   output ptc_pkg::dp_status_type        sts_o,
   input  ptc_pkg::req_payload_type      req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ptc_pkg::rsp_payload_type      rsp_payload,
   input  logic                          csr_valid,
   input  logic [ptc_pkg::RATE_W-1:0]    csr_data
);
   import ptc_pkg::*;

   localparam int CNT_W = $clog2(FEATURES + 1);
   localparam int IDX_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;

   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic [IDX_W-1:0]           upd_idx_ff, upd_idx_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [WEIGHT_W-1:0] bias_ff, bias_in;
   logic [RATE_W-1:0]          rate_ff, rate_in;
   req_payload_type            item_ff;
   logic                       in_range_ff;
   logic                       pred_ff, mistake_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_payload_type            rsp_ff;
   logic signed [32:0]         prod_ff;

   logic signed [FEAT_W-1:0]   feat_mem [FEATURES];
   logic signed [WEIGHT_W-1:0] weight_mem [FEATURES];
   logic [FEATURES-1:0]        wvalid_ff;
   logic signed [FEAT_W-1:0]   f_rd_ff;
   logic signed [WEIGHT_W-1:0] w_rd_ff;
   logic                       wv_rd_ff;

   logic                       in_range;
   logic                       w_re;
   logic [IDX_W-1:0]           w_ra;
   logic signed [WEIGHT_W-1:0] w_eff;
   logic signed [FEAT_W-1:0]   item_feat;
   logic signed [47:0]         mac_prod;
   logic signed [ACC_W:0]      sum_w;
   logic                       pred;
   logic signed [32:0]         step_prod;
   logic signed [32:0]         step;
   logic signed [WEIGHT_W+1:0] w_sum;
   logic signed [WEIGHT_W+1:0] b_sum;
   logic signed [WEIGHT_W+1:0] rate_ext;

   assign in_range  = idx_ff < CNT_W'(FEATURES);
   assign w_re      = (cmd_i.accept && in_range) || cmd_i.upd_rd;
   assign w_ra      = cmd_i.accept ? idx_ff[IDX_W-1:0] : upd_idx_ff;
   assign w_eff     = wv_rd_ff ? w_rd_ff : '0;
   assign item_feat = item_ff.feature_value;
   assign mac_prod  = item_feat * w_eff;
   assign sum_w     = (ACC_W+1)'(acc_ff) + (ACC_W+1)'($signed({bias_ff, 8'h00}));
   assign pred      = !sum_w[ACC_W] && (sum_w != '0);
   assign step_prod = f_rd_ff * $signed({1'b0, rate_ff});
   assign step      = prod_ff >>> 8;
   assign rate_ext  = (WEIGHT_W+2)'($signed({1'b0, rate_ff}));
   assign w_sum     = item_ff.label ? (WEIGHT_W+2)'(w_eff) + (WEIGHT_W+2)'(step)
                                    : (WEIGHT_W+2)'(w_eff) - (WEIGHT_W+2)'(step);
   assign b_sum     = item_ff.label ? (WEIGHT_W+2)'(bias_ff) + rate_ext
                                    : (WEIGHT_W+2)'(bias_ff) - rate_ext;

   always_comb begin
      idx_in       = idx_ff;
      upd_idx_in   = upd_idx_ff;
      acc_in       = acc_ff;
      bias_in      = bias_ff;
      rate_in      = csr_valid ? csr_data : rate_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd_i.mac && in_range_ff) begin
         acc_in = acc_ff + ACC_W'(mac_prod);
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd_i.bias) begin
         bias_in = sat32(b_sum);
      end
      if (cmd_i.upd_start) begin
         upd_idx_in = '0;
      end else if (cmd_i.upd_wr) begin
         upd_idx_in = upd_idx_ff + IDX_W'(1);
      end
      if (cmd_i.out_load) begin
         acc_in       = '0;
         idx_in       = '0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         acc_ff       <= '0;
         bias_ff      <= '0;
         rate_ff      <= RATE_RESET;
         rsp_valid_ff <= 1'b0;
         wvalid_ff    <= '0;
      end else begin
         idx_ff       <= idx_in;
         acc_ff       <= acc_in;
         bias_ff      <= bias_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd_i.upd_wr) begin
            wvalid_ff[upd_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      upd_idx_ff <= upd_idx_in;
      if (cmd_i.accept) begin
         item_ff     <= req_payload;
         in_range_ff <= in_range;
      end
      if (cmd_i.sum) begin
         pred_ff    <= pred;
         mistake_ff <= (item_ff.cmd == CMD_TRAIN) && (pred != item_ff.label);
      end
      if (cmd_i.upd_mul) begin
         prod_ff <= step_prod;
      end
      if (cmd_i.out_load) begin
         rsp_ff.predicted_class <= pred_ff;
         rsp_ff.mistake         <= mistake_ff;
      end
   end

   // feature store
   always_ff @(posedge clock) begin
      if (cmd_i.accept && in_range) begin
         feat_mem[idx_ff[IDX_W-1:0]] <= req_payload.feature_value;
      end
      if (cmd_i.upd_rd) begin
         f_rd_ff <= feat_mem[upd_idx_ff];
      end
   end

   // weight store
   always_ff @(posedge clock) begin
      if (cmd_i.upd_wr) begin
         weight_mem[upd_idx_ff] <= sat32(w_sum);
      end
      if (w_re) begin
         w_rd_ff  <= weight_mem[w_ra];
         wv_rd_ff <= wvalid_ff[w_ra];
      end
   end

   assign sts_o.last_item     = item_ff.last;
   assign sts_o.mistake       = mistake_ff;
   assign sts_o.count_nonzero = idx_ff != '0;
   assign sts_o.upd_more      = (CNT_W'(upd_idx_ff) + CNT_W'(1)) < idx_ff;
   assign sts_o.rsp_busy      = rsp_valid_ff && rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= CNT_W'(FEATURES))
      else $error("feature count beyond store depth");
   a_upd_bound: assert property (@(posedge clock) disable iff (reset)
      cmd_i.upd_wr |-> CNT_W'(upd_idx_ff) < idx_ff)
      else $error("weight update past buffered features");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd_i.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while held");

endmodule

FILE: rtl/ptc_controller.sv
// controller: sequences accept, accumulate, decision, weight update and result hand-off
module ptc_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ptc_pkg::dp_status_type sts_i,
   output ptc_pkg::ctl_cmd_type   cmd_o
);
   import ptc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAC,
      S_SUM,
      S_CHECK,
      S_UPD_RD,
      S_UPD_MUL,
      S_UPD_WR,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd_o           = '0;
      state_in        = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_o.accept = 1'b1;
               state_in     = S_MAC;
            end
         end
         S_MAC: begin
            cmd_o.mac = 1'b1;
            state_in  = sts_i.last_item ? S_SUM : S_IDLE;
         end
         S_SUM: begin
            cmd_o.sum = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            if (sts_i.mistake) begin
               cmd_o.bias      = 1'b1;
               cmd_o.upd_start = 1'b1;
               state_in        = sts_i.count_nonzero ? S_UPD_RD : S_OUT;
            end else begin
               state_in = S_OUT;
            end
         end
         S_UPD_RD: begin
            cmd_o.upd_rd = 1'b1;
            state_in     = S_UPD_MUL;
         end
         S_UPD_MUL: begin
            cmd_o.upd_mul = 1'b1;
            state_in      = S_UPD_WR;
         end
         S_UPD_WR: begin
            cmd_o.upd_wr = 1'b1;
            state_in     = sts_i.upd_more ? S_UPD_RD : S_OUT;
         end
         S_OUT: begin
            if (!sts_i.rsp_busy) begin
               cmd_o.out_load = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

   a_accept_mac: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == S_MAC)
      else $error("accepted item not accumulated");
   a_bias_on_mistake: assert property (@(posedge clock) disable iff (reset)
      cmd_o.bias |-> sts_i.mistake)
      else $error("bias moved without a mistake");
   a_upd_done: assert property (@(posedge clock) disable iff (reset)
      (cmd_o.upd_wr && !sts_i.upd_more) |=> state_ff == S_OUT)
      else $error("update loop did not finish to result");

endmodule

FILE: tb/ptc_predict_check.sv
// predicts perceptron verdicts from the observed channels and compares them with the results
`timescale 1ns / 100ps
module ptc_predict_check (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  ptc_pkg::req_payload_type    req_payload,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  ptc_pkg::rsp_payload_type    rsp_payload,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [ptc_pkg::RATE_W-1:0]  csr_data,
   output int                          error_count,
   output int                          verdicts_due
);
   import ptc_pkg::*;

   localparam int FEATURES = FEATURES_DEFAULT;
   localparam longint Q16_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint Q16_MIN = -64'sh0000_0000_8000_0000;

   logic signed [FEAT_W-1:0]   sample_features [FEATURES];
   logic signed [WEIGHT_W-1:0] weight_mem [FEATURES];
   logic signed [WEIGHT_W-1:0] bias_q16;
   longint                     dot_sum;
   int                         feature_count;
   logic [RATE_W-1:0]          rate_q016;
   rsp_payload_type            expected_verdicts [$];
   int                         mismatch_total = 0;
   int                         pending_total = 0;

   assign error_count = mismatch_total;
   assign verdicts_due = pending_total;

   function automatic logic signed [WEIGHT_W-1:0] clamp_q16(input longint v);
      longint c;
      c = v;
      if (c > Q16_MAX) begin
         c = Q16_MAX;
      end else if (c < Q16_MIN) begin
         c = Q16_MIN;
      end
      return c[WEIGHT_W-1:0];
   endfunction

   task automatic clear_model();
      int i;
      for (i = 0; i < FEATURES; i++) begin
         weight_mem[i] = '0;
         sample_features[i] = '0;
      end
      bias_q16 = '0;
      dot_sum = 0;
      feature_count = 0;
      rate_q016 = RATE_RESET;
      expected_verdicts.delete();
   endtask

   task automatic take_feature(input req_payload_type it);
      rsp_payload_type verdict;
      longint total;
      longint step;
      longint w;
      int i;
      if (feature_count < FEATURES) begin
         sample_features[feature_count] = it.feature_value;
         dot_sum += longint'($signed(it.feature_value)) * longint'(weight_mem[feature_count]);
         feature_count++;
      end
      if (it.last) begin
         total = dot_sum + longint'(bias_q16) * 256;
         verdict.predicted_class = (total > 0);
         verdict.mistake = 1'b0;
         if (it.cmd == CMD_TRAIN && verdict.predicted_class != it.label) begin
            verdict.mistake = 1'b1;
            for (i = 0; i < feature_count; i++) begin
               // q8.8 times q0.16 is q8.24, floor to q16.16
               step = (longint'($signed(sample_features[i])) * longint'({1'b0, rate_q016})) >>> 8;
               w = longint'(weight_mem[i]);
               weight_mem[i] = clamp_q16(it.label ? w + step : w - step);
            end
            if (it.label) begin
               bias_q16 = clamp_q16(longint'(bias_q16) + longint'({1'b0, rate_q016}));
            end else begin
               bias_q16 = clamp_q16(longint'(bias_q16) - longint'({1'b0, rate_q016}));
            end
         end
         expected_verdicts.push_back(verdict);
         dot_sum = 0;
         feature_count = 0;
      end
   endtask

   task automatic note_mismatch(input string what, input int want, input int got);
      mismatch_total++;
      if (mismatch_total <= 10) begin
         $display("mismatch %s: expected %0d, got %0d", what, want, got);
      end
   endtask

   task automatic check_verdict(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_verdicts.size() == 0) begin
         mismatch_total++;
         if (mismatch_total <= 10) begin
            $display("result with no item pending: predicted_class %0d, mistake %0d",
                     got.predicted_class, got.mistake);
         end
      end else begin
         want = expected_verdicts.pop_front();
         if (got.predicted_class !== want.predicted_class) begin
            note_mismatch("predicted_class", want.predicted_class, got.predicted_class);
         end
         if (got.mistake !== want.mistake) begin
            note_mismatch("mistake", want.mistake, got.mistake);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (csr_valid && csr_ready) begin
            rate_q016 = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            check_verdict(rsp_payload);
         end
         if (req_valid && !req_stall) begin
            take_feature(req_payload);
         end
      end
      pending_total <= expected_verdicts.size();
   end

endmodule

FILE: tb/tb_perceptron_train_classify.sv
// testbench top: drives samples and rate writes into the perceptron and reports the outcome
`timescale 1ns / 100ps
module tb_perceptron_train_classify;
   import ptc_pkg::*;

   localparam int FEATURES = FEATURES_DEFAULT;
   localparam int SETTLE_CYCLES = 5 + 3 * FEATURES + 16;
   localparam int LONG_HOLD = 400;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1080;
   localparam int PHASES = 6;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_payload_type     req_payload = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_payload_type     rsp_payload;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [RATE_W-1:0]   csr_data = '0;

   int   error_count;
   int   verdicts_due;
   int   cycle_count = 0;
   int   req_idle_max = 8;
   int   rsp_idle_max = 8;
   logic long_hold_due = 1'b0;

   logic signed [FEAT_W-1:0] corner_values [4] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};

   perceptron_train_classify #(.FEATURES(FEATURES)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   ptc_predict_check checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .error_count  (error_count),
      .verdicts_due (verdicts_due)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic offer_feature(input logic cmd, input logic signed [FEAT_W-1:0] value,
                                input logic label, input logic last);
      req_payload_type next_item;
      int gap;
      gap = $urandom_range(0, req_idle_max);
      next_item.cmd = cmd;
      next_item.feature_value = value;
      next_item.label = label;
      next_item.last = last;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= next_item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic signed [FEAT_W-1:0] pick_feature();
      if ($urandom_range(0, 3) == 0) begin
         return corner_values[2'($urandom_range(0, 3))];
      end
      return FEAT_W'($urandom());
   endfunction

   // one sample, sometimes longer than the weight set; cmd and label only count on the last item
   task automatic send_random_sample(output int sent);
      int len;
      int k;
      logic cmd;
      logic label;
      if ($urandom_range(0, 9) == 0) begin
         len = $urandom_range(FEATURES + 1, FEATURES + 6);
      end else begin
         len = $urandom_range(1, FEATURES);
      end
      cmd = ($urandom_range(0, 3) != 0) ? CMD_TRAIN : CMD_CLASSIFY;
      label = 1'($urandom_range(0, 1));
      for (k = 0; k < len - 1; k++) begin
         offer_feature(1'($urandom_range(0, 1)), pick_feature(), 1'($urandom_range(0, 1)),
                       1'b0);
      end
      offer_feature(cmd, pick_feature(), label, 1'b1);
      sent = len;
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rate(input logic [RATE_W-1:0] rate);
      settle_block();
      csr_data <= rate;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : result_sink
      int pause;
      forever begin
         pause = $urandom_range(0, rsp_idle_max);
         if (long_hold_due) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_due <= 1'b0;
         end else if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      logic [RATE_W-1:0] phase_rates [PHASES];
      int p;
      int k;
      int sent;
      int phase_items;
      phase_rates[0] = 16'hFFFF;
      phase_rates[1] = 16'h0000;
      phase_rates[2] = 16'h0001;
      phase_rates[3] = RATE_W'($urandom_range(2, 16'hFFFE));
      phase_rates[4] = RATE_RESET;
      phase_rates[5] = RATE_W'($urandom_range(2, 16'hFFFE));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // all-zero weights and bias: sum is zero, so class 0 even against label 1
      offer_feature(CMD_CLASSIFY, 16'sh7FFF, 1'b1, 1'b1);
      offer_feature(CMD_TRAIN, 16'sh8000, 1'b1, 1'b1);
      for (k = 0; k < 4; k++) begin
         offer_feature(CMD_TRAIN, corner_values[k], 1'b0, k == 3);
      end
      // more items than weights, the surplus is dropped
      for (k = 0; k < FEATURES + 2; k++) begin
         offer_feature(CMD_TRAIN, corner_values[k % 4] ^ 16'(k), 1'b1, k == FEATURES + 1);
      end

      for (p = 0; p < PHASES; p++) begin
         write_rate(phase_rates[p]);
         req_idle_max = (p == 2) ? 0 : 8;
         rsp_idle_max = (p == 2) ? 0 : 8;
         if (p == 1 || p == 4) begin
            long_hold_due <= 1'b1;
         end
         phase_items = 0;
         while (phase_items < RANDOM_ITEMS / PHASES) begin
            send_random_sample(sent);
            phase_items += sent;
         end
      end

      settle_block();
      if (error_count == 0 && verdicts_due == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
